// ===== sv/mac_tbl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC table package
// Shared types, field widths and operation and status codes for the MAC
// address table and its storage.
// ----------------------------------------------------------------------------
package mac_tbl_pkg;

  // Table geometry.
  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Fixed field widths of the beats.
  localparam int MAC_W         = 48;
  localparam int FUNC_W        = 2;
  localparam int START_W       = 7;
  localparam int STATUS_W      = 2;
  localparam int SLOT_FIELD_W  = 6;
  localparam int COUNT_FIELD_W = 7;

  // The randomized flag is bit 1 of the first octet.
  localparam logic [7:0] RANDOM_BIT_MASK = 8'h02;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ITERATE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [MAC_W-1:0]   mac;
    logic [START_W-1:0] start_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_FIELD_W-1:0]  slot_index;
    logic [COUNT_FIELD_W-1:0] next_index;
    logic [MAC_W-1:0]         slot_mac;
    logic                     randomized;
    logic [COUNT_FIELD_W-1:0] used_count;
  } out_item_t;

  // One stored table entry.
  typedef struct packed {
    logic             randomized;
    logic [MAC_W-1:0] mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== sv/mac_tbl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC table RAM
// Generic simple dual-port RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mac_tbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/mac_table_lookup_or_insert.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC table lookup or insert
// Table of MAC addresses with lookup, lookup-or-insert and iteration over
// the used slots, one result beat per input beat.
// ----------------------------------------------------------------------------
// The table holds SLOTS (64) entries in a single RAM, and every input beat
// yields exactly one result beat. Since entries are never removed and an
// insert always claims the lowest free slot, the used slots always form a
// contiguous run starting at slot zero, so the used-slot counter doubles as
// the valid map and as the pointer to the next free slot; reset clears it
// and the table is usable on the very next cycle, with no clearing pass.
// A lookup or lookup-or-insert compares the stored addresses against the
// request one slot per cycle through a single 48-bit comparator fed by the
// RAM's read port, stopping at the first match. Such a beat is accepted,
// compares the slots in use one at a time in the scan step and presents
// its result from the emit step. An iterate beat whose start slot is in
// use reads it in a fetch step before the emit step; otherwise, and for an
// unknown function code, the beat goes straight from acceptance to the
// emit step. The input is stalled while a beat is at work; a finished
// result sits in the output register and the next input beat is accepted
// while it waits to be taken. A second result that finishes while the
// first is still held waits in the emit step, and the input stalls.
// ----------------------------------------------------------------------------
module mac_table_lookup_or_insert (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire mac_tbl_pkg::in_item_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output mac_tbl_pkg::out_item_t      out_data
);

  import mac_tbl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state;
  logic [CNT_W-1:0]   used;
  logic [FUNC_W-1:0]  func_q;
  logic [MAC_W-1:0]   mac_q;
  logic [START_W-1:0] start_q;
  logic [CNT_W-1:0]   issue_idx;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_pending;
  out_item_t          res;

  logic               accept;
  logic               hit;
  logic               space_free;
  logic               more_to_scan;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  entry_t             wr_data;

  // A result carrying no slot: only the status and the count are set.
  function automatic out_item_t empty_result(input logic [STATUS_W-1:0] st,
                                             input logic [CNT_W-1:0] cnt);
    out_item_t r;
    r            = '0;
    r.status     = st;
    r.used_count = COUNT_FIELD_W'(cnt);
    return r;
  endfunction

  // A result that returns a slot together with its stored contents.
  function automatic out_item_t slot_result(input logic [STATUS_W-1:0]      st,
                                            input logic [SLOT_FIELD_W-1:0]  slot,
                                            input logic [COUNT_FIELD_W-1:0] nxt,
                                            input logic [MAC_W-1:0]         smac,
                                            input logic                     rnd,
                                            input logic [CNT_W-1:0]         cnt);
    out_item_t r;
    r            = empty_result(st, cnt);
    r.slot_index = slot;
    r.next_index = nxt;
    r.slot_mac   = smac;
    r.randomized = rnd;
    return r;
  endfunction

  mac_tbl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(used[IDX_W-1:0]),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign in_stall     = (state != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign hit          = cmp_pending && (rd_data.mac == mac_q);
  assign space_free   = (used < CNT_W'(SLOTS));
  assign more_to_scan = (issue_idx < used);

  assign wr_data.mac        = mac_q;
  assign wr_data.randomized = ((mac_q[47:40] & RANDOM_BIT_MASK) != 8'h00);

  // RAM port control. Reads are issued in the cycle before the compare.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    if (accept) begin
      if ((in_data.func == FUNC_LOOKUP || in_data.func == FUNC_INSERT) &&
          used != '0) begin
        rd_en = 1'b1;
      end else if (in_data.func == FUNC_ITERATE &&
                   CNT_W'(in_data.start_index) < used) begin
        rd_en   = 1'b1;
        rd_addr = in_data.start_index[IDX_W-1:0];
      end
    end else if (state == ST_SCAN && !hit) begin
      if (more_to_scan) begin
        rd_en   = 1'b1;
        rd_addr = issue_idx[IDX_W-1:0];
      end else if (func_q == FUNC_INSERT && space_free) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      used        <= '0;
      out_valid   <= 1'b0;
      cmp_pending <= 1'b0;
    end else begin
      // The output register is loaded from the emit step whenever it is empty
      // or being taken, and otherwise holds until the receiver takes it.
      out_valid <= (state == ST_EMIT && (!out_valid || !out_stall)) ||
                   (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= in_data.func;
            mac_q   <= in_data.mac;
            start_q <= in_data.start_index;
            unique case (in_data.func)
              FUNC_LOOKUP, FUNC_INSERT: begin
                cmp_idx     <= '0;
                cmp_pending <= (used != '0);
                issue_idx   <= (used != '0) ? CNT_W'(1) : '0;
                state       <= ST_SCAN;
              end
              FUNC_ITERATE: begin
                if (CNT_W'(in_data.start_index) < used) begin
                  state <= ST_FETCH;
                end else begin
                  res   <= empty_result(STATUS_NOT_FOUND, used);
                  state <= ST_EMIT;
                end
              end
              default: begin
                res   <= empty_result(STATUS_NOT_FOUND, used);
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res         <= slot_result(STATUS_FOUND, SLOT_FIELD_W'(cmp_idx), '0,
                                       rd_data.mac, rd_data.randomized, used);
            cmp_pending <= 1'b0;
            state       <= ST_EMIT;
          end else if (more_to_scan) begin
            cmp_idx     <= issue_idx[IDX_W-1:0];
            issue_idx   <= issue_idx + CNT_W'(1);
            cmp_pending <= 1'b1;
          end else begin
            cmp_pending <= 1'b0;
            state       <= ST_EMIT;
            if (func_q == FUNC_INSERT && space_free) begin
              used <= used + CNT_W'(1);
              res  <= slot_result(STATUS_ADDED, SLOT_FIELD_W'(used), '0, mac_q,
                                  wr_data.randomized, used + CNT_W'(1));
            end else if (func_q == FUNC_INSERT) begin
              res <= empty_result(STATUS_FULL, used);
            end else begin
              res <= empty_result(STATUS_NOT_FOUND, used);
            end
          end
        end
        ST_FETCH: begin
          res   <= slot_result(STATUS_FOUND, SLOT_FIELD_W'(start_q),
                               COUNT_FIELD_W'(start_q) + COUNT_FIELD_W'(1),
                               rd_data.mac, rd_data.randomized, used);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_data <= res;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The used-slot count can never pass the table size.
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(SLOTS))
    else $error("used-slot count exceeds table size");

  // Every RAM write claims exactly one new slot.
  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> used == $past(used) + CNT_W'(1))
    else $error("RAM write without matching count increment");

  // Reads only ever touch slots that are in use.
  a_read_in_use: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> CNT_W'(rd_addr) < used)
    else $error("read of a slot that is not in use");

  // A new result beat appears only out of the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result beat raised outside the emit step");

endmodule
`default_nettype wire

// ===== dv/mac_table_lookup_or_insert_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC table lookup or insert testbench
// Drives lookup, lookup-or-insert, iterate and unused-code beats, takes
// each expected result from a hand-typed row or a behavioural copy of the
// table and compares it field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module mac_table_lookup_or_insert_tb;
  import mac_tbl_pkg::*;

  // The one function code that the block does not define.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // A full-table search is the longest beat; the drain allows for that.
  localparam int DRAIN_CYCLES = 100;
  // Slowest correct run: roughly 1650 full-table searches plus idling, random
  // stalls and the long hold-off. The limit is several times that.
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_BEATS = 1630;
  // The receiver holds off for this long once enough beats have gone in.
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 300;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  mac_table_lookup_or_insert u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Behavioural copy of the table. Entries are never removed, so these only
  // ever grow after reset.
  logic             tbl_used [SLOTS];
  logic [MAC_W-1:0] tbl_mac  [SLOTS];
  logic             tbl_rnd  [SLOTS];
  int unsigned      tbl_count;

  out_item_t        pending_results[$];
  logic [MAC_W-1:0] seen_macs[$];
  int unsigned      errors    = 0;
  int unsigned      beats_in  = 0;
  // Set while neither side is allowed to idle.
  logic             steady    = 1'b0;
  // Set while the receiver is holding off for a long stretch.
  logic             hold_off  = 1'b0;

  // Applies one operation to the table copy and returns the result beat that
  // the block should produce for it.
  function automatic out_item_t apply_table_op(in_item_t beat);
    out_item_t r;
    int        hit;
    r   = '0;
    hit = -1;
    case (beat.func)
      FUNC_LOOKUP, FUNC_INSERT: begin
        // The lowest valid slot holding the address wins.
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_used[i] && tbl_mac[i] == beat.mac) hit = i;
        if (hit >= 0) begin
          r.status = STATUS_FOUND;
        end else if (beat.func == FUNC_LOOKUP) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          // No match, so claim the lowest free slot if there is one.
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && !tbl_used[i]) hit = i;
          if (hit >= 0) begin
            tbl_used[hit] = 1'b1;
            tbl_mac[hit]  = beat.mac;
            tbl_rnd[hit]  = (beat.mac[MAC_W-1 -: 8] & RANDOM_BIT_MASK) != 8'h00;
            tbl_count++;
            r.status = STATUS_ADDED;
          end else begin
            r.status = STATUS_FULL;
          end
        end
      end
      FUNC_ITERATE: begin
        // A start at or past the end of the table finds nothing.
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && i >= beat.start_index && tbl_used[i]) hit = i;
        if (hit >= 0) begin
          r.status     = STATUS_FOUND;
          r.next_index = COUNT_FIELD_W'(hit + 1);
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        // The unused code changes nothing and reports not found.
        r.status = STATUS_NOT_FOUND;
      end
    endcase
    if (hit >= 0) begin
      r.slot_index = SLOT_FIELD_W'(hit);
      r.slot_mac   = tbl_mac[hit];
      r.randomized = tbl_rnd[hit];
    end
    r.used_count = COUNT_FIELD_W'(tbl_count);
    return r;
  endfunction

  // Builds a result beat from its fields, for the rows typed in by hand.
  function automatic out_item_t result_beat(logic [STATUS_W-1:0] status, int slot, int nxt,
                                            logic [MAC_W-1:0] smac, logic rnd, int used);
    out_item_t r;
    r.status     = status;
    r.slot_index = SLOT_FIELD_W'(slot);
    r.next_index = COUNT_FIELD_W'(nxt);
    r.slot_mac   = smac;
    r.randomized = rnd;
    r.used_count = COUNT_FIELD_W'(used);
    return r;
  endfunction

  function automatic in_item_t op_beat(logic [FUNC_W-1:0] func, logic [MAC_W-1:0] mac,
                                       int start);
    in_item_t b;
    b.func        = func;
    b.mac         = mac;
    b.start_index = START_W'(start);
    return b;
  endfunction

  // Random beat. Half the addresses repeat ones already offered so that
  // lookups hit, and some differ from one of those in a single bit so that
  // the comparator sees near misses.
  function automatic in_item_t random_op_beat();
    in_item_t b;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 30)      b.func = FUNC_LOOKUP;
    else if (pick < 75) b.func = FUNC_INSERT;
    else if (pick < 93) b.func = FUNC_ITERATE;
    else                b.func = FUNC_UNUSED;
    pick = $urandom_range(99);
    if (pick < 50 && seen_macs.size() > 0)
      b.mac = seen_macs[$urandom_range(seen_macs.size() - 1)];
    else if (pick < 65 && seen_macs.size() > 0)
      b.mac = seen_macs[$urandom_range(seen_macs.size() - 1)]
              ^ (48'h1 << $urandom_range(MAC_W - 1));
    else
      b.mac = MAC_W'({$urandom(), $urandom()});
    if ($urandom_range(3) == 0) b.start_index = START_W'($urandom_range(127));
    else                        b.start_index = START_W'($urandom_range(SLOTS));
    if (b.func == FUNC_INSERT) seen_macs.push_back(b.mac);
    return b;
  endfunction

  // Offers one beat, idling at random beforehand, and records its expected
  // result once the block has taken it.
  task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t want);
    out_item_t pred;
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The table copy is updated on every beat, including the hand-typed ones.
    pred = apply_table_op(beat);
    pending_results.push_back(typed ? want : pred);
    beats_in++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $error("result beat with no expectation waiting");
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      errors++;
      $error("status: expected %0d, got %0d", want.status, got.status);
    end
    if (got.slot_index !== want.slot_index) begin
      errors++;
      $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
    end
    if (got.next_index !== want.next_index) begin
      errors++;
      $error("next_index: expected %0d, got %0d", want.next_index, got.next_index);
    end
    if (got.slot_mac !== want.slot_mac) begin
      errors++;
      $error("slot_mac: expected %012h, got %012h", want.slot_mac, got.slot_mac);
    end
    if (got.randomized !== want.randomized) begin
      errors++;
      $error("randomized: expected %0b, got %0b", want.randomized, got.randomized);
    end
    if (got.used_count !== want.used_count) begin
      errors++;
      $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
    end
  endtask

  // Receiver: takes a result beat whenever it is not stalling, and stalls at
  // random outside the steady window and throughout the hold-off.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result(out_data);
    out_stall <= hold_off || (!steady && $urandom_range(99) < 35);
  end

  // Long hold-off, counted here in cycles, while the sender keeps offering
  // beats: the output register fills, the next beat finishes behind it and
  // the input stalls.
  initial begin
    while (beats_in < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[mac_table_lookup_or_insert] ERROR");
    $finish;
  end

  initial begin
    in_item_t  beat;
    out_item_t none;
    none = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_mac[i]  = '0;
      tbl_rnd[i]  = 1'b0;
    end
    tbl_count = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Rows with a result typed in are checked against it;
    // the others against the table copy. The table starts empty.
    //        beat: func, mac, start                                   result
    send_beat(op_beat(FUNC_LOOKUP,  48'h0000_0000_0000,   0), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 0));
    send_beat(op_beat(FUNC_ITERATE, 48'h0000_0000_0000,   0), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 0));
    send_beat(op_beat(FUNC_UNUSED,  48'hFFFF_FFFF_FFFF, 127), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 0));
    send_beat(op_beat(FUNC_INSERT,  48'h0000_0000_0000,   0), 1'b1,
              result_beat(STATUS_ADDED, 0, 0, 48'h0000_0000_0000, 1'b0, 1));
    send_beat(op_beat(FUNC_INSERT,  48'hFFFF_FFFF_FFFF, 127), 1'b1,
              result_beat(STATUS_ADDED, 1, 0, 48'hFFFF_FFFF_FFFF, 1'b1, 2));
    send_beat(op_beat(FUNC_INSERT,  48'h0200_0000_0000,   0), 1'b1,
              result_beat(STATUS_ADDED, 2, 0, 48'h0200_0000_0000, 1'b1, 3));
    send_beat(op_beat(FUNC_INSERT,  48'hFDFF_FFFF_FFFF,   0), 1'b1,
              result_beat(STATUS_ADDED, 3, 0, 48'hFDFF_FFFF_FFFF, 1'b0, 4));
    send_beat(op_beat(FUNC_LOOKUP,  48'hFFFF_FFFF_FFFF,   0), 1'b1,
              result_beat(STATUS_FOUND, 1, 0, 48'hFFFF_FFFF_FFFF, 1'b1, 4));
    send_beat(op_beat(FUNC_INSERT,  48'h0000_0000_0000,   0), 1'b1,
              result_beat(STATUS_FOUND, 0, 0, 48'h0000_0000_0000, 1'b0, 4));
    send_beat(op_beat(FUNC_LOOKUP,  48'hFFFF_FFFF_FFFE,   0), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 4));
    send_beat(op_beat(FUNC_ITERATE, 48'hFFFF_FFFF_FFFF,   0), 1'b1,
              result_beat(STATUS_FOUND, 0, 1, 48'h0000_0000_0000, 1'b0, 4));
    send_beat(op_beat(FUNC_ITERATE, 48'h0000_0000_0000,   3), 1'b1,
              result_beat(STATUS_FOUND, 3, 4, 48'hFDFF_FFFF_FFFF, 1'b0, 4));
    send_beat(op_beat(FUNC_ITERATE, 48'h0000_0000_0000,   4), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 4));
    send_beat(op_beat(FUNC_ITERATE, 48'h0000_0000_0000,  64), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 4));
    send_beat(op_beat(FUNC_ITERATE, 48'h0000_0000_0000, 127), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 4));
    send_beat(op_beat(FUNC_UNUSED,  48'h0000_0000_0000,   0), 1'b1,
              result_beat(STATUS_NOT_FOUND, 0, 0, 48'h0, 1'b0, 4));
    send_beat(op_beat(FUNC_INSERT,  48'h8000_0000_0000,   0), 1'b1,
              result_beat(STATUS_ADDED, 4, 0, 48'h8000_0000_0000, 1'b0, 5));
    send_beat(op_beat(FUNC_LOOKUP,  48'h0000_0000_0001,   0), 1'b0, none);
    send_beat(op_beat(FUNC_INSERT,  48'h5A5A_5A5A_5A5A,  85), 1'b0, none);
    send_beat(op_beat(FUNC_ITERATE, 48'hA5A5_A5A5_A5A5,   2), 1'b0, none);

    // Random part. Inserts dominate, so the table fills early on and most
    // of the run exercises full-length searches and the full status.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      steady <= (n >= 700 && n < 1000);
      beat = random_op_beat();
      send_beat(beat, 1'b0, none);
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // Any stray beat after the last expected one would show up in here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[mac_table_lookup_or_insert] OK");
    end else begin
      $display("[mac_table_lookup_or_insert] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/mac_tbl_pkg.sv
sv/mac_tbl_ram.sv
sv/mac_table_lookup_or_insert.sv
dv/mac_table_lookup_or_insert_tb.sv
